@@ hdl/pcls_pkg.sv @@
// ----------------------------------------------------------------------------
// pcls_pkg
// shared types and constants of the pc-localized stride prefetcher
// ----------------------------------------------------------------------------
package pcls_pkg;

    localparam int PCLS_INDEX_ENTRIES   = 256;
    localparam int PCLS_HISTORY_ENTRIES = 256;
    localparam int PCLS_BLOCK_OFF_BITS  = 6;
    localparam int PCLS_ADDRESS_BITS    = 48;

    localparam int PCLS_FIELD_W  = 48;
    localparam int PCLS_SEQ_W    = 32;
    localparam int PCLS_DEG_W    = 4;
    localparam int PCLS_DIST_W   = 5;
    localparam int PCLS_CFG_IX_W = 2;
    localparam int PCLS_CFG_D_W  = 5;

    localparam logic [PCLS_DEG_W-1:0] PCLS_MAX_DEG = 4'd8;
    localparam logic [PCLS_SEQ_W-1:0] PCLS_NO_LINK = 32'hFFFF_FFFF;

    localparam logic [PCLS_CFG_IX_W-1:0] REG_DEGREE   = 2'd0;
    localparam logic [PCLS_CFG_IX_W-1:0] REG_DISTANCE = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IDX,
        ST_H0,
        ST_H1,
        ST_ISSUE,
        ST_WB
    } pcls_state_t;

    typedef enum logic [1:0] {
        ISP_IDLE,
        ISP_MUL,
        ISP_CHK,
        ISP_RUN
    } issue_phase_t;

    typedef struct packed {
        logic rdy;
        logic more;
        logic last;
    } issue_stat_t;

endpackage

@@ hdl/pcls_issue.sv @@
// ----------------------------------------------------------------------------
// pcls_issue
// stride issue unit: one shared adder walks block +/- stride*(distance+i)
// ----------------------------------------------------------------------------
module pcls_issue #(
    parameter int BW = 42
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_i,
    input  logic [BW-1:0]                 blk_i,
    input  logic [BW-1:0]                 mag_i,
    input  logic                          neg_i,
    input  logic [pcls_pkg::PCLS_DIST_W-1:0] dist_i,
    input  logic [pcls_pkg::PCLS_DEG_W-1:0]  deg_i,
    input  logic                          adv_i,
    output pcls_pkg::issue_stat_t         stat_o,
    output logic [BW-1:0]                 target_o
);
    import pcls_pkg::*;

    localparam int OFF_W = BW + 5;

    issue_phase_t           phase_reg, phase_next;
    logic [BW-1:0]          blk_reg, mag_reg;
    logic                   neg_reg;
    logic [PCLS_DIST_W-1:0] dist_reg;
    logic [PCLS_DEG_W-1:0]  deg_reg, cnt_reg;
    logic [OFF_W-1:0]       off_reg, off_next;
    logic                   ok_reg;
    logic [BW-1:0]          room;
    logic                   nxt_ok;

    // headroom toward the end of the range in the stride direction
    assign room     = neg_reg ? blk_reg : ~blk_reg;
    assign off_next = off_reg + OFF_W'(mag_reg);
    assign nxt_ok   = off_next <= OFF_W'(room);
    assign target_o = neg_reg ? blk_reg - off_reg[BW-1:0] : blk_reg + off_reg[BW-1:0];

    always_comb begin
        stat_o.rdy  = phase_reg == ISP_RUN;
        stat_o.more = ok_reg && (cnt_reg < deg_reg);
        stat_o.last = ((cnt_reg + 4'd1) == deg_reg) || !nxt_ok;
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            ISP_IDLE: phase_next = ISP_IDLE;
            ISP_MUL:  phase_next = ISP_CHK;
            ISP_CHK:  phase_next = ISP_RUN;
            ISP_RUN:  phase_next = ISP_RUN;
            default:  phase_next = ISP_IDLE;
        endcase
        if (load_i) phase_next = ISP_MUL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ISP_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            blk_reg  <= blk_i;
            mag_reg  <= mag_i;
            neg_reg  <= neg_i;
            dist_reg <= dist_i;
            deg_reg  <= (deg_i > PCLS_MAX_DEG) ? PCLS_MAX_DEG : deg_i;
        end else if (phase_reg == ISP_MUL) begin
            off_reg <= OFF_W'(mag_reg) * OFF_W'(dist_reg);
        end else if (phase_reg == ISP_CHK) begin
            ok_reg  <= off_reg <= OFF_W'(room);
            cnt_reg <= '0;
        end else if (phase_reg == ISP_RUN && adv_i) begin
            off_reg <= off_next;
            ok_reg  <= nxt_ok;
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

endmodule

@@ hdl/pc_localized_stride_prefetcher.sv @@
// ----------------------------------------------------------------------------
// pc_localized_stride_prefetcher
// pc-indexed global history buffer stride prefetcher with a sequenced datapath
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  s_      | in  | s_tvalid / s_tready  | access_address, instruction_address
//  m_      | out | m_tvalid / m_tready  | prefetch_address, tlast = last_prefetch
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  an access steps through ST_IDX and ST_H0, then ST_H1 once a usable index
//  link is found and ST_ISSUE once a stride is found, and ends in ST_WB; the
//  dependent index and history reads set this sequence
//  after reset a clearing pass sweeps every entry of the index table;
//  s_tready stays low meanwhile, config writes are taken at any time
//  a stalled m_ side holds the issue walk, the result register keeps its word
module pc_localized_stride_prefetcher #(
    parameter int INDEX_ENTRIES     = pcls_pkg::PCLS_INDEX_ENTRIES,
    parameter int HISTORY_ENTRIES   = pcls_pkg::PCLS_HISTORY_ENTRIES,
    parameter int BLOCK_OFFSET_BITS = pcls_pkg::PCLS_BLOCK_OFF_BITS,
    parameter int ADDRESS_BITS      = pcls_pkg::PCLS_ADDRESS_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [47:0] access_address, [95:48] instruction_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] prefetch_address
    output logic        m_tlast,   // last_prefetch
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pcls_pkg::PCLS_CFG_IX_W-1:0] cfg_index,
    input  logic [pcls_pkg::PCLS_CFG_D_W-1:0]  cfg_data
);
    import pcls_pkg::*;

    // table sizes are powers of two: index and slot are low bits
    localparam int IX_W  = $clog2(INDEX_ENTRIES);
    localparam int HS_W  = $clog2(HISTORY_ENTRIES);
    localparam int TAG_W = PCLS_FIELD_W - IX_W;
    localparam int BW    = ADDRESS_BITS - BLOCK_OFFSET_BITS;

    typedef struct packed {
        logic                  valid;
        logic [TAG_W-1:0]      tag;
        logic [PCLS_SEQ_W-1:0] ptr;
    } idx_entry_t;

    typedef struct packed {
        logic [BW-1:0]         blk;
        logic [PCLS_SEQ_W-1:0] seq;
        logic [PCLS_SEQ_W-1:0] prev;
        logic [TAG_W-1:0]      tag;
    } hist_entry_t;

    // memories
    idx_entry_t  idx_mem [INDEX_ENTRIES];
    hist_entry_t hist_mem [HISTORY_ENTRIES];
    idx_entry_t  idx_rd_reg;
    hist_entry_t hist_rd_reg;
    logic [IX_W-1:0] idx_rd_addr, idx_wr_addr;
    logic [HS_W-1:0] hist_rd_addr;
    idx_entry_t      idx_wr_data;
    logic            idx_we, hist_we;

    // sequencer and per-access registers
    pcls_state_t           state_reg, state_next;
    logic [IX_W-1:0]       clr_reg;
    logic [PCLS_SEQ_W-1:0] ic_reg;
    logic [BW-1:0]         blk_reg, h0_reg;
    logic [BW:0]           d1_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [IX_W-1:0]       ix_reg;
    logic [PCLS_SEQ_W-1:0] prev_reg, old_reg;
    logic                  pok_reg, ook_reg;
    logic [PCLS_DEG_W-1:0]  degree_reg;
    logic [PCLS_DIST_W-1:0] distance_reg;

    // result register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tlast_reg;

    // decoded input word
    logic [63:0]       in_addr64;
    logic [BW-1:0]     in_blk;
    logic [47:0]       in_pc;

    // per-state decisions
    logic              accept;
    logic [PCLS_SEQ_W-1:0] p_cand, o_cand;
    logic              p_arith_ok, o_arith_ok;
    logic              link0, link1, stride_hit;
    logic [BW:0]       d1_now, d2_now;
    logic              neg_now;
    logic [BW-1:0]     mag_now;

    // issue unit
    logic              iss_load, iss_adv, out_load;
    issue_stat_t       iss_stat;
    logic [BW-1:0]     iss_target;
    logic [63:0]       tgt_addr64;

    assign in_addr64 = 64'(s_tdata[47:0]);
    assign in_blk    = in_addr64[ADDRESS_BITS-1:BLOCK_OFFSET_BITS];
    assign in_pc     = s_tdata[95:48];

    assign s_tready  = state_reg == ST_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // link range checks: pointer must be older than the next insert and
    // not yet overwritten; a slot below the insert count was always written
    assign p_cand     = idx_rd_reg.ptr;
    assign p_arith_ok = (p_cand != PCLS_NO_LINK) && (p_cand < ic_reg)
                        && ((ic_reg - p_cand) <= PCLS_SEQ_W'(HISTORY_ENTRIES));
    assign o_cand     = hist_rd_reg.prev;
    assign o_arith_ok = (o_cand != PCLS_NO_LINK) && (o_cand < ic_reg)
                        && ((ic_reg - o_cand) <= PCLS_SEQ_W'(HISTORY_ENTRIES));

    assign link0 = pok_reg && (hist_rd_reg.seq == prev_reg) && (hist_rd_reg.tag == tag_reg);
    assign link1 = ook_reg && (hist_rd_reg.seq == old_reg) && (hist_rd_reg.tag == tag_reg);

    // strides as exact signed differences, one bit wider than a block number
    assign d1_now     = {1'b0, blk_reg} - {1'b0, hist_rd_reg.blk};
    assign d2_now     = {1'b0, h0_reg} - {1'b0, hist_rd_reg.blk};
    assign stride_hit = link1 && (d1_reg == d2_now) && (d1_reg != '0);
    assign neg_now    = d1_reg[BW];
    assign mag_now    = neg_now ? BW'(-d1_reg) : d1_reg[BW-1:0];

    assign tgt_addr64 = 64'({iss_target, {BLOCK_OFFSET_BITS{1'b0}}});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == IX_W'(INDEX_ENTRIES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_IDX;
            ST_IDX:   state_next = ST_H0;
            ST_H0:    state_next = link0 ? ST_H1 : ST_WB;
            ST_H1:    state_next = stride_hit ? ST_ISSUE : ST_WB;
            ST_ISSUE: begin
                if (iss_stat.rdy) begin
                    if (!iss_stat.more) state_next = ST_WB;
                    else if (out_load && iss_stat.last) state_next = ST_WB;
                end
            end
            ST_WB:    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        idx_rd_addr  = in_pc[IX_W-1:0];
        hist_rd_addr = (state_reg == ST_H0) ? o_cand[HS_W-1:0] : p_cand[HS_W-1:0];
        idx_we       = 1'b0;
        idx_wr_addr  = ix_reg;
        idx_wr_data  = '{valid: 1'b1, tag: tag_reg, ptr: ic_reg};
        hist_we      = 1'b0;
        iss_load     = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                idx_we      = 1'b1;
                idx_wr_addr = clr_reg;
                idx_wr_data = '0;
            end
            ST_H1:    iss_load = stride_hit;
            ST_ISSUE: out_load = iss_stat.rdy && iss_stat.more
                                 && (!m_tvalid_reg || m_tready);
            ST_WB: begin
                idx_we  = 1'b1;
                hist_we = 1'b1;
            end
            default: ;
        endcase
    end
    assign iss_adv = out_load;

    always_ff @(posedge aclk) begin
        idx_rd_reg  <= idx_mem[idx_rd_addr];
        hist_rd_reg <= hist_mem[hist_rd_addr];
        if (idx_we) idx_mem[idx_wr_addr] <= idx_wr_data;
        if (hist_we) begin
            hist_mem[ic_reg[HS_W-1:0]] <= '{blk: blk_reg, seq: ic_reg,
                                           prev: prev_reg, tag: tag_reg};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            ic_reg       <= '0;
            degree_reg   <= 4'd4;
            distance_reg <= 5'd1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_WB) ic_reg <= ic_reg + 1'b1;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEGREE:   degree_reg   <= cfg_data[PCLS_DEG_W-1:0];
                    REG_DISTANCE: distance_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // per-access payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                blk_reg <= in_blk;
                tag_reg <= in_pc[47:IX_W];
                ix_reg  <= in_pc[IX_W-1:0];
            end
            ST_IDX: begin
                prev_reg <= p_cand;
                pok_reg  <= p_arith_ok && idx_rd_reg.valid && (idx_rd_reg.tag == tag_reg);
            end
            ST_H0: begin
                if (!link0) prev_reg <= PCLS_NO_LINK;
                h0_reg  <= hist_rd_reg.blk;
                d1_reg  <= d1_now;
                old_reg <= o_cand;
                ook_reg <= o_arith_ok;
            end
            default: ;
        endcase
        if (out_load) begin
            m_tdata_reg <= tgt_addr64[47:0];
            m_tlast_reg <= iss_stat.last;
        end
    end

    pcls_issue #(
        .BW(BW)
    ) u_issue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (iss_load),
        .blk_i    (blk_reg),
        .mag_i    (mag_now),
        .neg_i    (neg_now),
        .dist_i   (distance_reg),
        .deg_i    (degree_reg),
        .adv_i    (iss_adv),
        .stat_o   (iss_stat),
        .target_o (iss_target)
    );

    // an accepted word starts the index lookup
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_IDX)
        else $error("accept did not start lookup");

    // the history pointer moves exactly once per write-back
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WB |=> ic_reg == $past(ic_reg) + 1'b1)
        else $error("insert count skipped");

    // a new result never overwrites a waiting one
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten");

endmodule
